// ===== design/crce_pkg.sv =====
`timescale 1ns / 1ps

package crce_pkg;

    // Table depth and the widths that follow from it
    localparam int POINTS_MAX = 256;
    localparam int IDX_W      = $clog2(POINTS_MAX);
    localparam int N_W        = IDX_W + 1;

    // Fixed field widths
    localparam int COORD_W    = 32;
    localparam int CNT_W      = 9;
    localparam int PARAM_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 32;
    localparam int ACC_W      = 64;

    localparam logic [CNT_W-1:0]   CNT_MIN   = CNT_W'(2);
    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(65536);

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic                       opcode;
        logic [7:0]                 point_index;
        logic signed [COORD_W-1:0]  in_x;
        logic signed [COORD_W-1:0]  in_y;
        logic signed [COORD_W-1:0]  in_z;
        logic [PARAM_W-1:0]         curve_param;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic signed [COORD_W-1:0]  out_z;
        logic [1:0]                 status;
    } result_t;

    // One control point as stored in the table
    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } point_t;

    typedef logic signed [WGT_W-1:0] weight_t;
    typedef weight_t [3:0]           weight_vec_t;

    // Accumulator control for one beat, one stage ahead of the accumulator
    typedef struct packed {
        logic en;
        logic first;
    } acc_ctl_t;

    // Tag that travels with each memory beat down the pipeline
    typedef struct packed {
        logic       valid;
        logic       load;
        logic       last;
        logic       first;
        logic [1:0] k;
        logic [1:0] status;
    } tag_t;

endpackage

// ===== design/catmull_rom_curve_eval_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     item   (crce_pkg::item_t)
// result    out        result_valid / result_stall result (crce_pkg::result_t)
// cfg       in         cfg_wr_en                   cfg_wr_data (point_count)
//
// A load takes one access of the point table port; an evaluate takes four,
// one read per control point, so loads sustain one per cycle while the
// result is not stalled. Results appear in acceptance order.
// Reset clears control state only; the point table holds garbage until loaded.
// A stalled result freezes the whole pipeline behind the output register.
module catmull_rom_curve_eval_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  crce_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output crce_pkg::result_t               result,
    input  logic                            cfg_wr_en,
    input  logic [crce_pkg::CNT_W-1:0]      cfg_wr_data
);

    localparam int IW = crce_pkg::IDX_W;
    localparam int NW = crce_pkg::N_W;
    localparam int PW = crce_pkg::PARAM_W + IW;

    // Configuration
    logic [crce_pkg::CNT_W-1:0] point_count_reg;

    // Issue stage: one item, stepped through its table accesses
    logic                   iss_valid_reg;
    logic                   iss_op_reg;
    logic                   iss_write_reg;
    logic [1:0]             iss_status_reg;
    logic [1:0]             iss_k_reg;
    logic [IW-1:0]          iss_idx_reg [4];
    logic [IW-1:0]          iss_slot_reg;
    crce_pkg::point_t       iss_pt_reg;
    logic [crce_pkg::FRAC_W-1:0] iss_frac_reg;

    // Beat tags down the pipeline
    crce_pkg::tag_t t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    crce_pkg::tag_t t1_next;

    logic                   result_valid_reg;
    crce_pkg::result_t      result_reg;

    // Accept-time decode
    logic [NW-1:0]          n_eff;
    logic [IW-1:0]          last;
    logic [crce_pkg::PARAM_W-1:0] t_c;
    logic [PW-1:0]          prod;
    logic [NW-1:0]          seg_raw;
    logic [IW-1:0]          seg;
    logic [crce_pkg::FRAC_W-1:0] frac;
    logic [IW-1:0]          idx_next [4];
    logic                   slot_ok;

    logic                   adv;
    logic                   iss_last;
    logic                   accept;
    logic                   mem_we;
    logic                   mem_re;
    logic [IW-1:0]          mem_addr;
    crce_pkg::point_t       rd_pt;
    crce_pkg::weight_vec_t  weights;
    crce_pkg::weight_t      mul_w;
    crce_pkg::acc_ctl_t     acc_ctl;
    logic signed [crce_pkg::COORD_W-1:0] res_x, res_y, res_z;
    crce_pkg::result_t      result_next;

    // Advance everything unless a finished result is held at the output
    assign adv        = !(result_valid_reg && result_stall);
    assign iss_last   = (iss_op_reg == crce_pkg::OP_LOAD) || (iss_k_reg == 2'd3);
    assign item_stall = iss_valid_reg && !(adv && iss_last);
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= crce_pkg::CNT_MIN;
        end
        else if (cfg_wr_en)
        begin
            point_count_reg <= cfg_wr_data;
        end
    end

    // Clamp count, scale t, split into segment and fraction, clamp neighbors
    always_comb
    begin
        if (point_count_reg < crce_pkg::CNT_MIN)
        begin
            n_eff = NW'(crce_pkg::CNT_MIN);
        end
        else if (32'(point_count_reg) > 32'(crce_pkg::POINTS_MAX))
        begin
            n_eff = NW'(crce_pkg::POINTS_MAX);
        end
        else
        begin
            n_eff = NW'(point_count_reg);
        end
        last = IW'(n_eff - NW'(1));

        t_c     = (item.curve_param > crce_pkg::PARAM_ONE) ? crce_pkg::PARAM_ONE
                                                           : item.curve_param;
        prod    = PW'(t_c) * PW'(last);
        seg_raw = prod[PW-1:crce_pkg::FRAC_W];
        if (seg_raw >= {1'b0, last})
        begin
            seg  = last;
            frac = '0;
        end
        else
        begin
            seg  = seg_raw[IW-1:0];
            frac = prod[crce_pkg::FRAC_W-1:0];
        end

        idx_next[0] = (seg == '0) ? '0 : seg - IW'(1);
        idx_next[1] = seg;
        idx_next[2] = (seg == last) ? last : seg + IW'(1);
        idx_next[3] = (({1'b0, seg} + NW'(2)) > {1'b0, last}) ? last : seg + IW'(2);

        slot_ok = 32'(item.point_index) < 32'(n_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_k_reg     <= 2'd0;
        end
        else if (accept)
        begin
            iss_valid_reg <= 1'b1;
            iss_k_reg     <= 2'd0;
        end
        else if (adv && iss_valid_reg)
        begin
            if (iss_last)
            begin
                iss_valid_reg <= 1'b0;
            end
            else
            begin
                iss_k_reg <= iss_k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iss_op_reg    <= item.opcode;
            iss_write_reg <= (item.opcode == crce_pkg::OP_LOAD) && slot_ok;
            if (item.opcode == crce_pkg::OP_EVAL)
            begin
                iss_status_reg <= crce_pkg::ST_EVAL;
            end
            else if (slot_ok)
            begin
                iss_status_reg <= crce_pkg::ST_LOADED;
            end
            else
            begin
                iss_status_reg <= crce_pkg::ST_RANGE;
            end
            for (int i = 0; i < 4; i++)
            begin
                iss_idx_reg[i] <= idx_next[i];
            end
            iss_slot_reg  <= IW'(item.point_index);
            iss_pt_reg.x  <= item.in_x;
            iss_pt_reg.y  <= item.in_y;
            iss_pt_reg.z  <= item.in_z;
            iss_frac_reg  <= frac;
        end
    end

    // Table port: write for a load, one neighbor read per evaluate beat
    assign mem_we   = adv && iss_valid_reg && iss_write_reg;
    assign mem_re   = adv && iss_valid_reg && (iss_op_reg == crce_pkg::OP_EVAL);
    assign mem_addr = (iss_op_reg == crce_pkg::OP_LOAD) ? iss_slot_reg
                                                         : iss_idx_reg[iss_k_reg];

    crce_ptab u_ptab (
        .clk     (clk),
        .wr_en   (mem_we),
        .rd_en   (mem_re),
        .addr    (mem_addr),
        .wr_data (iss_pt_reg),
        .rd_data (rd_pt)
    );

    // Weights are registered in the weight generator, in time for the point
    // that has been held two stages past the table
    crce_wgen u_wgen (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .start   (mem_re && (iss_k_reg == 2'd0)),
        .frac    (iss_frac_reg),
        .weights (weights)
    );

    always_comb
    begin
        t1_next.valid  = iss_valid_reg;
        t1_next.load   = (iss_op_reg == crce_pkg::OP_LOAD);
        t1_next.last   = iss_last;
        t1_next.first  = (iss_k_reg == 2'd0);
        t1_next.k      = iss_k_reg;
        t1_next.status = iss_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else if (adv)
        begin
            t1_reg <= t1_next;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    assign mul_w         = weights[t3_reg.k];
    assign acc_ctl.en    = t4_reg.valid && !t4_reg.load;
    assign acc_ctl.first = t4_reg.first;

    crce_axis u_axis_x (
        .clk      (clk),
        .adv      (adv),
        .rd_point (rd_pt.x),
        .weight   (mul_w),
        .acc_ctl  (acc_ctl),
        .result   (res_x)
    );

    crce_axis u_axis_y (
        .clk      (clk),
        .adv      (adv),
        .rd_point (rd_pt.y),
        .weight   (mul_w),
        .acc_ctl  (acc_ctl),
        .result   (res_y)
    );

    crce_axis u_axis_z (
        .clk      (clk),
        .adv      (adv),
        .rd_point (rd_pt.z),
        .weight   (mul_w),
        .acc_ctl  (acc_ctl),
        .result   (res_z)
    );

    // Loads report zeros; an evaluate reports on its last beat only
    always_comb
    begin
        result_next.out_x  = t5_reg.load ? '0 : res_x;
        result_next.out_y  = t5_reg.load ? '0 : res_y;
        result_next.out_z  = t5_reg.load ? '0 : res_z;
        result_next.status = t5_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= t5_reg.valid && t5_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/crce_ptab.sv =====
`timescale 1ns / 1ps

// Point table: single port, one access per cycle, registered read data.
module crce_ptab (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic                           rd_en,
    input  logic [crce_pkg::IDX_W-1:0]     addr,
    input  crce_pkg::point_t               wr_data,
    output crce_pkg::point_t               rd_data
);

    crce_pkg::point_t mem [crce_pkg::POINTS_MAX];
    crce_pkg::point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        else if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/crce_wgen.sv =====
`timescale 1ns / 1ps

// Catmull-Rom basis weights in Q2.30 from a 16-bit fraction, three stages.
module crce_wgen (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            start,
    input  logic [crce_pkg::FRAC_W-1:0]     frac,
    output crce_pkg::weight_vec_t           weights
);

    localparam int WW = 54;

    logic                          v1_reg;
    logic                          v2_reg;
    logic [crce_pkg::FRAC_W-1:0]   f1_reg;
    logic [crce_pkg::FRAC_W-1:0]   f1b_reg;
    logic [2*crce_pkg::FRAC_W-1:0] f2_reg;
    logic [2*crce_pkg::FRAC_W-1:0] f2b_reg;
    logic [3*crce_pkg::FRAC_W-1:0] f3_reg;
    crce_pkg::weight_vec_t         w_reg;

    logic signed [WW-1:0] fs;
    logic signed [WW-1:0] f2s;
    logic signed [WW-1:0] f3s;
    logic signed [WW-1:0] wide [4];
    logic signed [WW-1:0] rnd  [4];
    crce_pkg::weight_vec_t w_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // Square, then cube, each behind a register
    always_ff @(posedge clk)
    begin
        if (adv && start)
        begin
            f1_reg <= frac;
            f2_reg <= (2*crce_pkg::FRAC_W)'(frac) * (2*crce_pkg::FRAC_W)'(frac);
        end
        if (adv && v1_reg)
        begin
            f1b_reg <= f1_reg;
            f2b_reg <= f2_reg;
            f3_reg  <= (3*crce_pkg::FRAC_W)'(f2_reg) * (3*crce_pkg::FRAC_W)'(f1_reg);
        end
        if (adv && v2_reg)
        begin
            w_reg <= w_next;
        end
    end

    always_comb
    begin
        fs  = $signed(WW'(f1b_reg));
        f2s = $signed(WW'(f2b_reg));
        f3s = $signed(WW'(f3_reg));

        // Weights scaled by 2^49
        wide[0] = -f3s + (f2s <<< 17) - (fs <<< 32);
        wide[1] = (f3s <<< 1) + f3s - (f2s <<< 18) - (f2s <<< 16)
                  + (WW'(1) <<< 49);
        wide[2] = -((f3s <<< 1) + f3s) + (f2s <<< 18) + (fs <<< 32);
        wide[3] = f3s - (f2s <<< 16);

        for (int i = 0; i < 4; i++)
        begin
            rnd[i]    = (wide[i] + (WW'(1) <<< 18)) >>> 19;
            w_next[i] = rnd[i][crce_pkg::WGT_W-1:0];
        end
    end

    assign weights = w_reg;

endmodule

// ===== design/crce_axis.sv =====
`timescale 1ns / 1ps

// One axis: delay the point to meet its weight, multiply, accumulate four
// beats, round to Q15.16 and saturate.
module crce_axis (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [crce_pkg::COORD_W-1:0] rd_point,
    input  crce_pkg::weight_t                   weight,
    input  crce_pkg::acc_ctl_t                  acc_ctl,
    output logic signed [crce_pkg::COORD_W-1:0] result
);

    logic signed [crce_pkg::COORD_W-1:0] d2_reg;
    logic signed [crce_pkg::COORD_W-1:0] d3_reg;
    logic signed [crce_pkg::ACC_W-1:0]   prod_reg;
    logic signed [crce_pkg::ACC_W-1:0]   acc_reg;

    logic signed [crce_pkg::ACC_W-1:0]   prod_next;
    logic signed [crce_pkg::ACC_W-1:0]   rsum;

    assign prod_next = crce_pkg::ACC_W'(d3_reg) * crce_pkg::ACC_W'($signed(weight));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg   <= rd_point;
            d3_reg   <= d2_reg;
            prod_reg <= prod_next;
            if (acc_ctl.en)
            begin
                acc_reg <= acc_ctl.first ? prod_reg : acc_reg + prod_reg;
            end
        end
    end

    // Round half up at bit 30, then clamp to the 32-bit range
    always_comb
    begin
        rsum = acc_reg + (crce_pkg::ACC_W'(1) <<< 29);
        if ((rsum[63] == rsum[62]) && (rsum[62] == rsum[61]))
        begin
            result = rsum[61:30];
        end
        else if (rsum[63])
        begin
            result = {1'b1, {(crce_pkg::COORD_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(crce_pkg::COORD_W-1){1'b1}}};
        end
    end

endmodule

// ===== test/catmull_rom_curve_eval_top_tb.sv =====
`timescale 1ns / 1ps

module catmull_rom_curve_eval_top_tb;

    import crce_pkg::*;

    // Four table slots and the fraction that one evaluate works on
    typedef struct packed {
        logic [3:0][7:0]     idx;
        logic [FRAC_W-1:0]   frac;
    } span_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    item_t              item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result;
    logic               cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;

    catmull_rom_curve_eval_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Beats waiting to be offered, and curve points still owed by the block
    item_t      queued_items [$];
    result_t    expected_points [$];

    // Predictor copy of the block: control point table and the count register
    point_t             curve_pts [POINTS_MAX];
    logic [CNT_W-1:0]   model_count = CNT_MIN;

    // Stimulus planning: count in force and which slots hold a known point
    int unsigned    plan_n = 2;
    bit             slot_loaded [POINTS_MAX];

    // Idle and stall rates in percent, plus a one-shot long receiver hold-off
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    stall_hold_request = 0;
    int unsigned    stall_hold_left = 0;

    bit             beat_taken = 1'b0;
    int unsigned    error_count = 0;
    int unsigned    results_checked = 0;
    int unsigned    loads_seen = 0;
    int unsigned    range_seen = 0;
    int unsigned    evals_seen = 0;
    int unsigned    saturated_seen = 0;
    int unsigned    settings_used = 1;

    function automatic int unsigned clamp_count(logic [CNT_W-1:0] c);
        if (c < CNT_MIN)
        begin
            return CNT_MIN;
        end
        if (c > POINTS_MAX)
        begin
            return POINTS_MAX;
        end
        return c;
    endfunction

    // Split t * (n - 1) into a segment and a fraction, pick the four neighbors
    function automatic span_t span_of(int unsigned n, logic [PARAM_W-1:0] t);
        span_t       sp;
        int unsigned tt;
        int unsigned last;
        int unsigned prod;
        int unsigned seg;
        tt = (t > PARAM_ONE) ? PARAM_ONE : t;
        last = n - 1;
        prod = tt * last;
        seg = prod >> FRAC_W;
        sp.frac = FRAC_W'(prod);
        // end of curve: pin to the last point with no fraction
        if (seg >= last)
        begin
            seg = last;
            sp.frac = '0;
        end
        sp.idx[0] = 8'((seg == 0) ? 0 : seg - 1);
        sp.idx[1] = 8'(seg);
        sp.idx[2] = 8'((seg + 1 > last) ? last : seg + 1);
        sp.idx[3] = 8'((seg + 2 > last) ? last : seg + 2);
        return sp;
    endfunction

    // Advance the predictor by one accepted beat and return the curve point it owes
    function automatic result_t predict_beat(item_t it);
        result_t             res;
        span_t               sp;
        int unsigned         n;
        longint              fr;
        longint              f2;
        longint              f3;
        longint              acc;
        longint              sum;
        longint              wide [4];
        longint              w [4];
        point_t              p;
        logic signed [31:0]  v;
        int                  a;
        int                  k;
        res = '0;
        n = clamp_count(model_count);
        if (it.opcode == OP_LOAD)
        begin
            loads_seen++;
            if (it.point_index >= n)
            begin
                range_seen++;
                res.status = ST_RANGE;
            end
            else
            begin
                curve_pts[it.point_index] = {it.in_x, it.in_y, it.in_z};
                res.status = ST_LOADED;
            end
            return res;
        end
        evals_seen++;
        sp = span_of(n, it.curve_param);
        fr = longint'(sp.frac);
        f2 = fr * fr;
        f3 = f2 * fr;
        // Basis weights scaled by 2^49, then rounded to Q2.30
        wide[0] = -f3 + (f2 <<< 17) - (fr <<< 32);
        wide[1] = 3 * f3 - 5 * (f2 <<< 16) + (longint'(1) <<< 49);
        wide[2] = -3 * f3 + 4 * (f2 <<< 16) + (fr <<< 32);
        wide[3] = f3 - (f2 <<< 16);
        for (k = 0; k < 4; k++)
        begin
            w[k] = (wide[k] + (longint'(1) <<< 18)) >>> 19;
        end
        for (a = 0; a < 3; a++)
        begin
            acc = 0;
            for (k = 0; k < 4; k++)
            begin
                p = curve_pts[sp.idx[k]];
                v = (a == 0) ? p.x : (a == 1) ? p.y : p.z;
                acc += longint'(v) * w[k];
            end
            sum = (acc + (longint'(1) <<< 29)) >>> 30;
            if (sum > 64'sd2147483647)
            begin
                v = 32'sh7fff_ffff;
            end
            else if (sum < -64'sd2147483648)
            begin
                v = 32'sh8000_0000;
            end
            else
            begin
                v = sum[31:0];
            end
            if (v == 32'sh7fff_ffff || v == 32'sh8000_0000)
            begin
                saturated_seen++;
            end
            case (a)
                0:       res.out_x = v;
                1:       res.out_y = v;
                default: res.out_z = v;
            endcase
        end
        res.status = ST_EVAL;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at result %0d (t=%0t): %s", results_checked, $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // Sample both handshakes and the config write at the rising edge.
    // Check the result first: it always belongs to a beat taken earlier.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                model_count = cfg_wr_data;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    result_t want;
                    want = expected_points.pop_front();
                    check_field("out_x", result.out_x, want.out_x);
                    check_field("out_y", result.out_y, want.out_y);
                    check_field("out_z", result.out_z, want.out_z);
                    check_field("status", 32'(result.status), 32'(want.status));
                end
                results_checked++;
            end
            if (item_valid && !item_stall)
            begin
                expected_points.push_back(predict_beat(item));
                beat_taken = 1'b1;
            end
        end
    end

    // Sender: hold the beat until taken, then offer the next one or go idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (queued_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item <= queued_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: a requested hold-off wins over the random stall rate
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (stall_hold_left != 0)
        begin
            stall_hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_hold_request != 0)
        begin
            stall_hold_left = stall_hold_request;
            stall_hold_request = 0;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sh1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PARAM_ONE;
            2:       return PARAM_W'($urandom_range(65537, 131071));
            default: return PARAM_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic add_load(int unsigned slot, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z);
        item_t it;
        it.opcode = OP_LOAD;
        it.point_index = 8'(slot);
        it.in_x = x;
        it.in_y = y;
        it.in_z = z;
        it.curve_param = PARAM_W'($urandom_range(0, 131071));
        if (slot < plan_n)
        begin
            slot_loaded[slot] = 1'b1;
        end
        queued_items.push_back(it);
    endtask

    // Load any neighbor that never got a point, so no evaluate reads garbage
    task automatic add_eval(logic [PARAM_W-1:0] t);
        item_t it;
        span_t sp;
        int    k;
        sp = span_of(plan_n, t);
        for (k = 0; k < 4; k++)
        begin
            if (!slot_loaded[sp.idx[k]])
            begin
                add_load(sp.idx[k], rand_coord(), rand_coord(), rand_coord());
            end
        end
        it.opcode = OP_EVAL;
        it.point_index = 8'($urandom);
        it.in_x = $urandom;
        it.in_y = $urandom;
        it.in_z = $urandom;
        it.curve_param = t;
        queued_items.push_back(it);
    endtask

    task automatic add_random_items(int unsigned count);
        int unsigned slot;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                if (plan_n < POINTS_MAX && $urandom_range(0, 6) == 0)
                begin
                    slot = $urandom_range(plan_n, POINTS_MAX - 1);
                end
                else
                begin
                    slot = $urandom_range(0, plan_n - 1);
                end
                add_load(slot, rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                add_eval(rand_param());
            end
        end
    endtask

    // Wait until every beat is taken and every curve point has come back.
    // Look at the rising edge, where the sender's last offer has settled.
    task automatic drain();
        while (queued_items.size() != 0 || item_valid || expected_points.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write point_count with the block idle; no beat may share the write edge
    task automatic write_count(logic [CNT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        plan_n = clamp_count(value);
        settings_used++;
    endtask

    task automatic set_pace(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int k;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats at the reset count of two points
        set_pace(0, 0);
        add_load(0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0);
        add_load(1, 32'sh8000_0000, 32'sh7fff_ffff, -32'sh1);
        add_load(2, 32'sh1234_5678, 32'sh0, 32'sh0);        // just past the end
        add_load(255, -32'sh1, -32'sh1, -32'sh1);           // top slot, out of range
        add_eval(17'd0);
        add_eval(PARAM_ONE);                                 // end of curve
        add_eval(17'd131071);                                // above one, all bits set
        add_eval(17'd65537);
        add_eval(17'd32768);
        add_eval(17'd1);
        add_eval(17'd65535);
        add_load(0, rand_coord(), rand_coord(), rand_coord());
        add_load(1, 32'sh0001_0000, -32'sh0001_0000, 32'sh0);
        add_eval(17'd16384);
        add_eval(17'd49152);

        // Full table, back to back
        write_count(9'd256);
        add_eval(PARAM_ONE);
        add_random_items(70);

        // Five points, sender mostly idle; drive the sum past full scale
        write_count(9'd5);
        set_pace(83, 0);
        for (k = 0; k < 4; k++)
        begin
            if (k == 0 || k == 3)
            begin
                add_load(k, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
            end
            else
            begin
                add_load(k, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
            end
        end
        add_eval(17'd24576);
        add_random_items(100);

        // Count below the minimum, receiver mostly stalled
        write_count(9'd1);
        set_pace(0, 83);
        add_random_items(80);

        // Count above the table depth, both sides idling now and then
        write_count(9'd511);
        set_pace(33, 33);
        add_random_items(100);

        // Zero count: hold the receiver off long enough that the block backs up
        write_count(9'd0);
        set_pace(0, 0);
        stall_hold_request = 400;
        add_random_items(60);

        // Odd count; pause the sender halfway until every result is back
        write_count(9'd37);
        set_pace(33, 33);
        add_random_items(50);
        drain();
        add_random_items(50);

        drain();
        repeat (20) @(negedge clk);
        if (expected_points.size() != 0)
        begin
            report_mismatch("curve points still expected at end of run");
        end

        $display("Covered %0d loads (%0d out of range) and %0d evaluations over %0d count settings",
                 loads_seen, range_seen, evals_seen, settings_used);
        $display("Checked %0d result beats; %0d axis values hit saturation",
                 results_checked, saturated_seen);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
